@@ sv/slcp_pkg.sv @@
// Shared types and constants for the serial limit command parser.
// No dependencies; used by the channel interfaces, the parser core and the top level.
package slcp_pkg;

	localparam int ValueW = 14;
	localparam int EventW = 4;

	// characters of interest
	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_N    = 8'd110;
	localparam logic [7:0] CH_X    = 8'd120;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;

	localparam logic [ValueW-1:0] VALUE_CAP  = 14'd9999;
	localparam logic [ValueW-1:0] LOW_RESET  = 14'd50;
	localparam logic [ValueW-1:0] HIGH_RESET = 14'd150;

	// event codes returned with each echoed word
	localparam logic [EventW-1:0] EV_NONE    = 4'd0;
	localparam logic [EventW-1:0] EV_CONFIRM = 4'd1;
	localparam logic [EventW-1:0] EV_MIN_ASK = 4'd2;
	localparam logic [EventW-1:0] EV_MAX_ASK = 4'd3;
	localparam logic [EventW-1:0] EV_BAD_SEQ = 4'd4;
	localparam logic [EventW-1:0] EV_DIGIT   = 4'd5;
	localparam logic [EventW-1:0] EV_MIN_SET = 4'd6;
	localparam logic [EventW-1:0] EV_MAX_SET = 4'd7;
	localparam logic [EventW-1:0] EV_ERROR   = 4'd8;

	typedef struct packed {
		logic [7:0]        echo_byte;
		logic [EventW-1:0] event_res;
		logic [ValueW-1:0] value;
		logic [ValueW-1:0] low_limit;
		logic [ValueW-1:0] high_limit;
		logic              sampling_on;
	} result_t;

	// handshake from the input stage to the parser core
	typedef struct packed {
		logic       step;
		logic [7:0] rx_byte;
	} step_t;

endpackage

@@ sv/slcp_channels.sv @@
// Valid/ready channel interfaces for the parser: received bytes in, results out.
// Depends on slcp_pkg for field widths.
interface slcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcp_out_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    echo_byte;
	logic [slcp_pkg::EventW-1:0]   event_res;
	logic [slcp_pkg::ValueW-1:0]   value;
	logic [slcp_pkg::ValueW-1:0]   low_limit;
	logic [slcp_pkg::ValueW-1:0]   high_limit;
	logic                          sampling_on;

	modport source (output valid, output echo_byte, output event_res, output value,
		output low_limit, output high_limit, output sampling_on, input ready);
	modport sink   (input valid, input echo_byte, input event_res, input value,
		input low_limit, input high_limit, input sampling_on, output ready);
endinterface

@@ sv/slcp_parser.sv @@
// Command state machine with the limit registers and the registered result word.
// Depends on slcp_pkg.
module slcp_parser #(
	parameter int MAX_DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slcp_pkg::step_t   step_in,
	output slcp_pkg::result_t res_q
);

	localparam int CntW = $clog2(MAX_DIGITS + 1);
	localparam int SumW = slcp_pkg::ValueW + 4;

	typedef enum logic [2:0] {
		IDLE,
		ASK_MIN,
		ASK_MAX,
		ENTER_MIN,
		ENTER_MAX
	} mode_t;

	mode_t                       mode_q, mode_d;
	logic [CntW-1:0]             cnt_q, cnt_d;
	logic [slcp_pkg::ValueW-1:0] acc_q, acc_d;
	logic [slcp_pkg::ValueW-1:0] low_q, low_d;
	logic [slcp_pkg::ValueW-1:0] high_q, high_d;
	logic                        samp_q, samp_d;
	slcp_pkg::result_t           res_d;

	logic [7:0]                  c;
	logic                        is_digit;
	logic                        room;
	logic [SumW-1:0]             sum;
	logic [slcp_pkg::ValueW-1:0] acc_next;
	logic [slcp_pkg::EventW-1:0] ev;
	logic [slcp_pkg::ValueW-1:0] val;

	assign c        = step_in.rx_byte;
	assign is_digit = (c >= slcp_pkg::CH_ZERO) && (c <= slcp_pkg::CH_NINE);
	assign room     = cnt_q < CntW'(MAX_DIGITS);
	// digits '0'..'9' carry their value in the low nibble
	assign sum      = SumW'(acc_q) * SumW'(10) + SumW'(c[3:0]);
	assign acc_next = (sum > SumW'(slcp_pkg::VALUE_CAP)) ? slcp_pkg::VALUE_CAP
		: sum[slcp_pkg::ValueW-1:0];

	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		acc_d  = acc_q;
		low_d  = low_q;
		high_d = high_q;
		samp_d = samp_q;
		ev     = slcp_pkg::EV_NONE;
		val    = '0;
		case (mode_q)
			IDLE: begin
				if (c == slcp_pkg::CH_N) begin
					mode_d = ASK_MIN;
					samp_d = 1'b0;
					ev     = slcp_pkg::EV_CONFIRM;
				end else if (c == slcp_pkg::CH_X) begin
					mode_d = ASK_MAX;
					samp_d = 1'b0;
					ev     = slcp_pkg::EV_CONFIRM;
				end
			end
			ASK_MIN, ASK_MAX: begin
				if (c == slcp_pkg::CH_CR) begin
					mode_d = (mode_q == ASK_MIN) ? ENTER_MIN : ENTER_MAX;
					ev     = (mode_q == ASK_MIN) ? slcp_pkg::EV_MIN_ASK : slcp_pkg::EV_MAX_ASK;
					acc_d  = '0;
					cnt_d  = '0;
				end else begin
					mode_d = IDLE;
					cnt_d  = '0;
					samp_d = 1'b1;
					ev     = slcp_pkg::EV_BAD_SEQ;
				end
			end
			ENTER_MIN, ENTER_MAX: begin
				if (is_digit && room) begin
					acc_d = acc_next;
					cnt_d = cnt_q + CntW'(1);
					ev    = slcp_pkg::EV_DIGIT;
					val   = acc_next;
				end else begin
					mode_d = IDLE;
					cnt_d  = '0;
					samp_d = 1'b1;
					if (c == slcp_pkg::CH_CR && room) begin
						if (mode_q == ENTER_MIN) begin
							low_d = acc_q;
							ev    = slcp_pkg::EV_MIN_SET;
						end else begin
							high_d = acc_q;
							ev     = slcp_pkg::EV_MAX_SET;
						end
						val = acc_q;
					end else begin
						ev = slcp_pkg::EV_ERROR;
					end
				end
			end
			default: begin
				mode_d = IDLE;
			end
		endcase

		res_d.echo_byte   = c;
		res_d.event_res   = ev;
		res_d.value       = val;
		res_d.low_limit   = low_d;
		res_d.high_limit  = high_d;
		res_d.sampling_on = samp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= IDLE;
			cnt_q  <= '0;
			acc_q  <= '0;
			low_q  <= slcp_pkg::LOW_RESET;
			high_q <= slcp_pkg::HIGH_RESET;
			samp_q <= 1'b1;
			res_q  <= '0;
		end else if (step_in.step) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			low_q  <= low_d;
			high_q <= high_d;
			samp_q <= samp_d;
			res_q  <= res_d;
		end
	end

endmodule

@@ sv/serial_limit_command_parser_top.sv @@
// Top level of the serial limit command parser: input register, output register and handshake.
// Depends on slcp_pkg, the slcp channel interfaces and slcp_parser.

// Accepts one received byte per clock and returns one result word per byte; the whole command
// update sits between the input register and the result register, so a full-rate stream runs
// at one byte per cycle whenever the sink keeps ready high. A stalled sink holds the result
// register, and one more byte waits in the input register before ready drops. MAX_DIGITS (1
// to 8) caps the digits of an entry; a return stores a limit only below MAX_DIGITS digits.
module serial_limit_command_parser_top #(
	parameter int MAX_DIGITS = 4
) (
	input logic        clk,
	input logic        arst_n,
	slcp_in_if.sink    in_ch,
	slcp_out_if.source res_ch
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	logic              move;
	slcp_pkg::step_t   step;
	slcp_pkg::result_t res;

	assign move         = valid_s1 && (!out_valid_q || res_ch.ready);
	assign in_ch.ready  = !valid_s1 || move;
	assign step.step    = move;
	assign step.rx_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	slcp_parser #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step_in(step),
		.res_q  (res)
	);

	assign res_ch.valid       = out_valid_q;
	assign res_ch.echo_byte   = res.echo_byte;
	assign res_ch.event_res   = res.event_res;
	assign res_ch.value       = res.value;
	assign res_ch.low_limit   = res.low_limit;
	assign res_ch.high_limit  = res.high_limit;
	assign res_ch.sampling_on = res.sampling_on;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for serial_limit_command_parser_top: drives received bytes, predicts
// every echoed word in step with acceptance and checks it. Depends on slcp_pkg and the channels.
module tb_top;

	localparam int MAX_DIGITS = 4;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_ASK_MIN, MODE_ASK_MAX, MODE_ENTER_MIN, MODE_ENTER_MAX
	} cmd_mode_t;

	logic clk;
	logic arst_n;

	slcp_in_if  in_ch ();
	slcp_out_if res_ch ();

	serial_limit_command_parser_top #(.MAX_DIGITS(MAX_DIGITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.res_ch (res_ch)
	);

	// predicted parser state
	cmd_mode_t                   cmd_mode;
	int                          digit_cnt;
	logic [slcp_pkg::ValueW-1:0] acc;
	logic [slcp_pkg::ValueW-1:0] low_thr;
	logic [slcp_pkg::ValueW-1:0] high_thr;
	logic                        sampling;

	slcp_pkg::result_t awaited_echo[$];
	int                bytes_sent;
	int                mismatches;
	bit                gaps_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic void back_to_idle();
		digit_cnt = 0;
		cmd_mode  = MODE_IDLE;
		sampling  = 1'b1;
	endfunction

	function automatic slcp_pkg::result_t parse_byte(input logic [7:0] c);
		slcp_pkg::result_t r;
		int                sum;
		r.echo_byte = c;
		r.event_res = slcp_pkg::EV_NONE;
		r.value     = '0;
		case (cmd_mode)
			MODE_IDLE: begin
				if (c == slcp_pkg::CH_N) begin
					cmd_mode    = MODE_ASK_MIN;
					sampling    = 1'b0;
					r.event_res = slcp_pkg::EV_CONFIRM;
				end else if (c == slcp_pkg::CH_X) begin
					cmd_mode    = MODE_ASK_MAX;
					sampling    = 1'b0;
					r.event_res = slcp_pkg::EV_CONFIRM;
				end
			end
			MODE_ASK_MIN, MODE_ASK_MAX: begin
				if (c == slcp_pkg::CH_CR) begin
					r.event_res = (cmd_mode == MODE_ASK_MIN) ? slcp_pkg::EV_MIN_ASK
						: slcp_pkg::EV_MAX_ASK;
					cmd_mode    = (cmd_mode == MODE_ASK_MIN) ? MODE_ENTER_MIN
						: MODE_ENTER_MAX;
					acc         = '0;
					digit_cnt   = 0;
				end else begin
					back_to_idle();
					r.event_res = slcp_pkg::EV_BAD_SEQ;
				end
			end
			default: begin
				if (c >= slcp_pkg::CH_ZERO && c <= slcp_pkg::CH_NINE
						&& digit_cnt < MAX_DIGITS) begin
					sum = int'(acc) * 10 + int'(c - slcp_pkg::CH_ZERO);
					acc = (sum > int'(slcp_pkg::VALUE_CAP)) ? slcp_pkg::VALUE_CAP
						: slcp_pkg::ValueW'(sum);
					digit_cnt++;
					r.event_res = slcp_pkg::EV_DIGIT;
					r.value     = acc;
				end else if (c == slcp_pkg::CH_CR && digit_cnt < MAX_DIGITS) begin
					if (cmd_mode == MODE_ENTER_MIN) begin
						low_thr     = acc;
						r.event_res = slcp_pkg::EV_MIN_SET;
					end else begin
						high_thr    = acc;
						r.event_res = slcp_pkg::EV_MAX_SET;
					end
					r.value = acc;
					back_to_idle();
				end else begin
					back_to_idle();
					r.event_res = slcp_pkg::EV_ERROR;
				end
			end
		endcase
		r.low_limit   = low_thr;
		r.high_limit  = high_thr;
		r.sampling_on = sampling;
		return r;
	endfunction

	// one byte in; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_byte <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		awaited_echo.push_back(parse_byte(b));
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (awaited_echo.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// sink side: random stall bursts while gaps are on
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 9) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		slcp_pkg::result_t got;
		slcp_pkg::result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.echo_byte, res_ch.event_res, res_ch.value,
				res_ch.low_limit, res_ch.high_limit, res_ch.sampling_on};
			if (awaited_echo.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: echo %0d event %0d", got.echo_byte,
						got.event_res);
			end else begin
				want = awaited_echo.pop_front();
				if (got.echo_byte !== want.echo_byte || got.event_res !== want.event_res
						|| got.value !== want.value || got.low_limit !== want.low_limit
						|| got.high_limit !== want.high_limit
						|| got.sampling_on !== want.sampling_on) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp echo %0d ev %0d val %0d lo %0d hi %0d smp %0d",
							" / got echo %0d ev %0d val %0d lo %0d hi %0d smp %0d"},
							want.echo_byte, want.event_res, want.value, want.low_limit,
							want.high_limit, want.sampling_on, got.echo_byte, got.event_res,
							got.value, got.low_limit, got.high_limit, got.sampling_on);
				end
			end
		end
	end

	task automatic test_idle_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(slcp_pkg::CH_ZERO + 8'd5);
		send_byte(slcp_pkg::CH_CR);
	endtask

	task automatic test_bad_sequence();
		send_byte(slcp_pkg::CH_N);
		send_byte(slcp_pkg::CH_N);
		send_byte(slcp_pkg::CH_X);
		send_byte(8'h00);
	endtask

	task automatic test_min_set();
		send_byte(slcp_pkg::CH_N);
		send_byte(slcp_pkg::CH_CR);
		send_byte(slcp_pkg::CH_ZERO + 8'd1);
		send_byte(slcp_pkg::CH_ZERO + 8'd2);
		send_byte(slcp_pkg::CH_ZERO + 8'd3);
		send_byte(slcp_pkg::CH_CR);
	endtask

	// return straight after the max ask stores zero
	task automatic test_max_empty();
		send_byte(slcp_pkg::CH_X);
		send_byte(slcp_pkg::CH_CR);
		send_byte(slcp_pkg::CH_CR);
	endtask

	// return once the digit budget is used up is an error
	task automatic test_too_many_digits();
		send_byte(slcp_pkg::CH_X);
		send_byte(slcp_pkg::CH_CR);
		repeat (MAX_DIGITS)
			send_byte(slcp_pkg::CH_NINE);
		send_byte(slcp_pkg::CH_CR);
	endtask

	task automatic send_command();
		logic [7:0] b;
		int         n;
		send_byte($urandom_range(0, 1) ? slcp_pkg::CH_N : slcp_pkg::CH_X);
		b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : slcp_pkg::CH_CR;
		send_byte(b);
		if (b != slcp_pkg::CH_CR)
			return;
		n = $urandom_range(0, MAX_DIGITS + 1);
		repeat (n)
			send_byte(slcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : slcp_pkg::CH_CR;
		send_byte(b);
	endtask

	task automatic test_random_commands(input int target);
		while (bytes_sent < target) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(0, 255)));
			else
				send_command();
		end
	endtask

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.rx_byte = 8'h00;
		arst_n        = 1'b0;
		gaps_on       = 1'b1;
		bytes_sent    = 0;
		mismatches    = 0;
		cmd_mode      = MODE_IDLE;
		digit_cnt     = 0;
		acc           = '0;
		low_thr       = slcp_pkg::LOW_RESET;
		high_thr      = slcp_pkg::HIGH_RESET;
		sampling      = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_bytes();
		test_bad_sequence();
		test_min_set();
		test_max_empty();
		test_too_many_digits();
		drain();
		test_random_commands(950);
		gaps_on = 1'b0;
		test_random_commands(1150);
		drain();

		repeat (10) @(posedge clk);
		if (awaited_echo.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ serial_limit_command_parser_top.f @@
sv/slcp_pkg.sv
sv/slcp_channels.sv
sv/slcp_parser.sv
sv/serial_limit_command_parser_top.sv
sim/tb_top.sv
